/* design/lpl_pkg.sv */
package lpl_pkg;

  localparam int DIST_W   = 24;
  localparam int POS_W    = 5;
  localparam int LOG_FRAC = 16;
  localparam int LOG_W    = POS_W + LOG_FRAC;

  localparam int EXP_W  = 12;
  localparam int LOSS_W = 16;
  localparam int PWR_W  = 16;
  localparam int RX_W   = 20;
  localparam int BASE_W = 18;
  localparam int DIFF_W = LOG_W;
  localparam int T_W    = EXP_W + DIFF_W;
  localparam int K_W    = 18;
  localparam int PROD_W = T_W + K_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int PL_W   = SUM_W - 2 * LOG_FRAC;
  localparam int ACC_W  = 22;

  localparam int NSTAGE = 8;

  localparam logic [K_W-1:0] TEN_LOG10_2 = 18'd197283;

  localparam int RX_MAX = 524287;
  localparam int RX_MIN = -524288;

  localparam logic [EXP_W-1:0]  EXP_RESET  = 12'd768;
  localparam logic [DIST_W-1:0] DIST_RESET = 24'd256;
  localparam logic [LOSS_W-1:0] LOSS_RESET = 16'd11949;

  typedef enum logic [1:0] {
    CFG_EXPONENT = 2'd0,
    CFG_REF_DIST = 2'd1,
    CFG_REF_LOSS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     near;
    logic signed [BASE_W-1:0] base;
    logic signed [PWR_W-1:0]  shadow;
  } side_t;

endpackage

/* design/lpl_log2.sv */
module lpl_log2
  import lpl_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DIST_W-1:0] x,
  output logic [LOG_W-1:0]  log_val
);

  localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES);
  localparam int MUL_W = DIST_W + $clog2(LOG_TABLE_ENTRIES + 1);

  function automatic logic [LOG_FRAC-1:0] rom_entry(input int unsigned i);
    longint unsigned m;
    logic [LOG_FRAC-1:0] y;
    m = (64'd1 << 30) + ((longint'(i) << 30) / LOG_TABLE_ENTRIES);
    y = '0;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        y[LOG_FRAC-k] = 1'b1;
      end
    end
    return y;
  endfunction

  logic [LOG_FRAC-1:0] rom [LOG_TABLE_ENTRIES];

  for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_rom
    assign rom[g] = rom_entry(g);
  end

  // leading one
  logic [POS_W-1:0] pos;
  always_comb begin
    pos = '0;
    for (int b = 0; b < DIST_W; b++) begin
      if (x[b]) pos = POS_W'(b);
    end
  end

  logic [DIST_W-1:0] x_a_r;
  logic [POS_W-1:0]  p_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r <= x;
      p_a_r <= pos;
    end
  end

  // mantissa index
  logic [DIST_W-1:0] frac;
  logic [MUL_W-1:0]  scaled;
  logic [MUL_W-1:0]  shifted;
  logic [IDX_W-1:0]  idx_nxt;

  always_comb begin
    frac    = x_a_r - (DIST_W'(1) << p_a_r);
    scaled  = MUL_W'(frac) * MUL_W'(LOG_TABLE_ENTRIES);
    shifted = scaled >> p_a_r;
    if (shifted >= MUL_W'(LOG_TABLE_ENTRIES)) begin
      idx_nxt = IDX_W'(LOG_TABLE_ENTRIES - 1);
    end else begin
      idx_nxt = shifted[IDX_W-1:0];
    end
  end

  logic [POS_W-1:0] p_b_r;
  logic [IDX_W-1:0] idx_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_b_r   <= p_a_r;
      idx_b_r <= idx_nxt;
    end
  end

  logic [LOG_W-1:0] log_r;

  always_ff @(posedge clk) begin
    if (en) begin
      log_r <= {p_b_r, rom[idx_b_r]};
    end
  end

  assign log_val = log_r;

endmodule

/* design/log_distance_path_loss.sv */
// Log-distance path loss with shadowing: one transaction is accepted per clock while in_stall is
// low; throughput is one item per cycle when the output does not stall, set by an eight-stage
// pipeline (input capture, three log2 stages per distance, log difference, exponent multiply,
// constant multiply, and a final round, add and clamp into the output register). A stall on
// the output while a result waits freezes every stage at once, so nothing is lost or repeated.
// Configuration registers are read by items in flight and should be written only while the
// pipeline is empty.
module log_distance_path_loss
  import lpl_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [DIST_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PWR_W-1:0] in_tx_power,
  input  logic [DIST_W-1:0]       in_link_distance,
  input  logic signed [PWR_W-1:0] in_shadow_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RX_W-1:0]  out_rx_power,
  output logic                    out_near_field,
  output logic                    out_saturated
);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(RX_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(RX_MIN);

  // configuration
  logic [EXP_W-1:0]  exp_r;
  logic [DIST_W-1:0] ref_dist_r;
  logic [LOSS_W-1:0] ref_loss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r      <= EXP_RESET;
      ref_dist_r <= DIST_RESET;
      ref_loss_r <= LOSS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXPONENT: exp_r      <= cfg_data[EXP_W-1:0];
        CFG_REF_DIST: ref_dist_r <= cfg_data;
        CFG_REF_LOSS: ref_loss_r <= cfg_data[LOSS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic              en;
  logic [NSTAGE-1:0] vld_r;

  assign en       = !vld_r[NSTAGE-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  // stage 1: reference select, near test, base power
  logic [DIST_W-1:0] d0;
  side_t             side_in;

  always_comb begin
    d0             = (ref_dist_r == '0) ? DIST_W'(1) : ref_dist_r;
    side_in.near   = (in_link_distance <= d0);
    side_in.base   = BASE_W'(in_tx_power) - $signed({2'b00, ref_loss_r});
    side_in.shadow = in_shadow_sample;
  end

  logic [DIST_W-1:0] d_r;
  logic [DIST_W-1:0] d0_r;
  side_t             side_r [1:7];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r       <= in_link_distance;
      d0_r      <= d0;
      side_r[1] <= side_in;
      for (int s = 2; s <= 7; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // stages 2 to 4: log2 of both distances
  logic [LOG_W-1:0] log_d;
  logic [LOG_W-1:0] log_d0;

  lpl_log2 #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) u_log_d (
    .clk    (clk),
    .en     (en),
    .x      (d_r),
    .log_val(log_d)
  );

  lpl_log2 #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) u_log_d0 (
    .clk    (clk),
    .en     (en),
    .x      (d0_r),
    .log_val(log_d0)
  );

  // stages 5 to 7: difference and two multiplies
  logic [DIFF_W-1:0] diff_r;
  logic [T_W-1:0]    t_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= log_d - log_d0;
      t_r    <= T_W'(exp_r) * T_W'(diff_r);
      prod_r <= PROD_W'(t_r) * PROD_W'(TEN_LOG10_2);
    end
  end

  // stage 8: round, combine, clamp
  logic [SUM_W-1:0]        rnd;
  logic [PL_W-1:0]         pl;
  logic signed [ACC_W-1:0] base_x;
  logic signed [ACC_W-1:0] shadow_x;
  logic signed [ACC_W-1:0] acc;
  logic [RX_W-1:0]         rx_nxt;
  logic                    sat_nxt;

  always_comb begin
    rnd      = SUM_W'(prod_r) + (SUM_W'(1) << (2 * LOG_FRAC - 1));
    pl       = rnd[SUM_W-1:2*LOG_FRAC];
    base_x   = ACC_W'(side_r[7].base);
    shadow_x = ACC_W'(side_r[7].shadow);
    if (side_r[7].near) begin
      acc = base_x;
    end else begin
      acc = base_x - $signed({{(ACC_W-PL_W){1'b0}}, pl}) + shadow_x;
    end
    sat_nxt = 1'b0;
    if (acc > ACC_HI) begin
      rx_nxt  = ACC_HI[RX_W-1:0];
      sat_nxt = 1'b1;
    end else if (acc < ACC_LO) begin
      rx_nxt  = ACC_LO[RX_W-1:0];
      sat_nxt = 1'b1;
    end else begin
      rx_nxt = acc[RX_W-1:0];
    end
  end

  logic [RX_W-1:0] rx_r;
  logic            near_r;
  logic            sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= rx_nxt;
      near_r <= side_r[7].near;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid      = vld_r[NSTAGE-1];
  assign out_rx_power   = $signed(rx_r);
  assign out_near_field = near_r;
  assign out_saturated  = sat_r;

endmodule

/* tb/log_distance_path_loss_checker.sv */
`timescale 1ns / 1ps
module log_distance_path_loss_checker
  import lpl_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [DIST_W-1:0]       cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [PWR_W-1:0] in_tx_power,
  input  logic [DIST_W-1:0]       in_link_distance,
  input  logic signed [PWR_W-1:0] in_shadow_sample,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [RX_W-1:0]  out_rx_power,
  input  logic                    out_near_field,
  input  logic                    out_saturated,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct packed {
    logic signed [RX_W-1:0] rx_power;
    logic                   near_field;
    logic                   saturated;
  } rx_result_t;

  logic [EXP_W-1:0]    exponent_q;
  logic [DIST_W-1:0]   ref_dist_q;
  logic [LOSS_W-1:0]   ref_loss_q;
  logic [LOG_FRAC-1:0] mantissa_rom [LOG_TABLE_ENTRIES];
  rx_result_t          expected_rx_q [$];

  // log2 of 1 + i/entries by repeated squaring
  function automatic logic [LOG_FRAC-1:0] mantissa_entry(int i);
    logic [63:0]         m;
    logic [LOG_FRAC-1:0] y;
    m = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
    y = '0;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        y[LOG_FRAC-k] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic logic [63:0] log2_q16(logic [DIST_W-1:0] x);
    int          p;
    logic [63:0] idx;
    p = 0;
    for (int b = 0; b < DIST_W; b++) begin
      if (x[b]) p = b;
    end
    idx = ((64'(x) - (64'd1 << p)) * LOG_TABLE_ENTRIES) >> p;
    if (idx >= LOG_TABLE_ENTRIES) idx = LOG_TABLE_ENTRIES - 1;
    return (64'(p) << LOG_FRAC) + 64'(mantissa_rom[idx]);
  endfunction

  function automatic rx_result_t predict_rx(logic signed [PWR_W-1:0] tx,
                                            logic [DIST_W-1:0] d,
                                            logic signed [PWR_W-1:0] sh);
    logic [DIST_W-1:0] d0;
    logic [63:0]       diff;
    logic [63:0]       loss_db;
    longint            rx;
    rx_result_t        r;
    d0 = (ref_dist_q == '0) ? DIST_W'(1) : ref_dist_q;
    rx = longint'(tx) - longint'(ref_loss_q);
    r.near_field = (d <= d0);
    r.saturated  = 1'b0;
    if (!r.near_field) begin
      diff    = log2_q16(d) - log2_q16(d0);
      loss_db = (64'(exponent_q) * diff * 64'(TEN_LOG10_2) + (64'd1 << (2 * LOG_FRAC - 1)))
                >> (2 * LOG_FRAC);
      rx      = rx - longint'(loss_db) + longint'(sh);
    end
    if (rx > RX_MAX) begin
      rx = RX_MAX;
      r.saturated = 1'b1;
    end else if (rx < RX_MIN) begin
      rx = RX_MIN;
      r.saturated = 1'b1;
    end
    r.rx_power = rx[RX_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) mantissa_rom[i] = mantissa_entry(i);
  end

  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (!rst_n) begin
      exponent_q = EXP_RESET;
      ref_dist_q = DIST_RESET;
      ref_loss_q = LOSS_RESET;
      expected_rx_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_EXPONENT: exponent_q = cfg_data[EXP_W-1:0];
          CFG_REF_DIST: ref_dist_q = cfg_data;
          CFG_REF_LOSS: ref_loss_q = cfg_data[LOSS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.rx_power   = out_rx_power;
        got.near_field = out_near_field;
        got.saturated  = out_saturated;
        if (expected_rx_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, rx_power %0d", got.rx_power));
        end else begin
          want = expected_rx_q.pop_front();
          if (got.rx_power !== want.rx_power)
            report_mismatch($sformatf("rx_power %0d, expected %0d",
                                      got.rx_power, want.rx_power));
          if (got.near_field !== want.near_field)
            report_mismatch($sformatf("near_field %0b, expected %0b",
                                      got.near_field, want.near_field));
          if (got.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      got.saturated, want.saturated));
        end
      end
      if (in_valid && !in_stall)
        expected_rx_q.push_back(predict_rx(in_tx_power, in_link_distance, in_shadow_sample));
    end
    outstanding = expected_rx_q.size();
  end

endmodule

/* tb/log_distance_path_loss_tb.sv */
`timescale 1ns / 1ps
module log_distance_path_loss_tb;
  import lpl_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [DIST_W-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [PWR_W-1:0] in_tx_power;
  logic [DIST_W-1:0]       in_link_distance;
  logic signed [PWR_W-1:0] in_shadow_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [RX_W-1:0]  out_rx_power;
  logic                    out_near_field;
  logic                    out_saturated;

  int                fail_count;
  int                outstanding;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_req;
  int                hold_left;
  logic [DIST_W-1:0] ref_dist_now;

  log_distance_path_loss i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tx_power      (in_tx_power),
    .in_link_distance (in_link_distance),
    .in_shadow_sample (in_shadow_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rx_power     (out_rx_power),
    .out_near_field   (out_near_field),
    .out_saturated    (out_saturated)
  );

  log_distance_path_loss_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tx_power      (in_tx_power),
    .in_link_distance (in_link_distance),
    .in_shadow_sample (in_shadow_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rx_power     (out_rx_power),
    .out_near_field   (out_near_field),
    .out_saturated    (out_saturated),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic send_item(input logic signed [PWR_W-1:0] tx, input logic [DIST_W-1:0] d,
                           input logic signed [PWR_W-1:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_tx_power      <= tx;
    in_link_distance <= d;
    in_shadow_sample <= sh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [DIST_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [EXP_W-1:0] n, input logic [DIST_W-1:0] d0,
                            input logic [LOSS_W-1:0] loss);
    drain();
    write_cfg(CFG_EXPONENT, DIST_W'(n));
    write_cfg(CFG_REF_DIST, d0);
    write_cfg(CFG_REF_LOSS, DIST_W'(loss));
    ref_dist_now = d0;
  endtask

  task automatic pick_config();
    logic [EXP_W-1:0]  n;
    logic [DIST_W-1:0] d0;
    logic [LOSS_W-1:0] loss;
    int                p;
    case ($urandom_range(5))
      0:       n = '0;
      1:       n = '1;
      default: n = EXP_W'($urandom_range(4095));
    endcase
    p = $urandom_range(20);
    case ($urandom_range(7))
      0:       d0 = '0;
      1:       d0 = DIST_W'(1);
      2:       d0 = '1;
      default: d0 = DIST_W'((32'd1 << p) | ($urandom() & ((32'd1 << p) - 1)));
    endcase
    case ($urandom_range(5))
      0:       loss = '0;
      1:       loss = '1;
      default: loss = LOSS_W'($urandom());
    endcase
    set_config(n, d0, loss);
  endtask

  task automatic send_random();
    logic [DIST_W-1:0] d;
    int                p;
    int                near_d;
    p = $urandom_range(DIST_W - 1);
    near_d = (ref_dist_now == '0) ? 1 : int'(ref_dist_now);
    near_d = near_d + int'($urandom_range(6)) - 3;
    if (near_d < 0) near_d = 0;
    if (near_d > 24'hFFFFFF) near_d = 24'hFFFFFF;
    case ($urandom_range(3))
      0:       d = DIST_W'($urandom());
      1:       d = DIST_W'((32'd1 << p) | ($urandom() & ((32'd1 << p) - 1)));
      2:       d = DIST_W'(near_d);
      default: d = DIST_W'($urandom_range(15));
    endcase
    send_item(PWR_W'($urandom()), d, PWR_W'($urandom()));
  endtask

  // receiver side, long hold-off counted here
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = 300;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_EXPONENT;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_tx_power      = '0;
    in_link_distance = '0;
    in_shadow_sample = '0;
    send_idle_pct    = 28;
    recv_stall_pct   = 28;
    hold_req         = 0;
    ref_dist_now     = DIST_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero distance, exactly at d0, just beyond, far extremes
    send_item(16'sh0000, 24'd0, 16'sh0000);
    send_item(16'sh7FFF, 24'd256, 16'sh7FFF);
    send_item(-16'sh8000, 24'd257, -16'sh8000);
    send_item(16'sh7FFF, 24'hFFFFFF, 16'sh7FFF);
    send_item(-16'sh8000, 24'hFFFFFF, -16'sh8000);
    send_item(16'sh0000, 24'd512, 16'sh0000);
    send_item(16'sh0000, 24'h800000, 16'sh0100);

    set_config('1, DIST_W'(1), '0);
    send_item(16'sh7FFF, 24'd2, 16'sh7FFF);
    send_item(-16'sh8000, 24'hFFFFFF, -16'sh8000);
    send_item(16'sh7FFF, 24'd1, -16'sh8000);
    send_item(16'sh0000, 24'd0, 16'sh7FFF);

    set_config('0, '1, '1);
    send_item(-16'sh8000, 24'hFFFFFF, 16'sh7FFF);
    send_item(16'sh7FFF, 24'hFFFFFE, 16'sh7FFF);
    send_item(16'sh0000, 24'd0, 16'sh0000);

    // zero reference distance behaves as the smallest step
    set_config(EXP_RESET, '0, LOSS_RESET);
    send_item(16'sh0000, 24'd1, 16'sh0000);
    send_item(16'sh0000, 24'd0, 16'sh7FFF);
    send_item(16'sh1234, 24'd2, 16'sh0100);
    send_item(16'sh0000, 24'hFFFFFF, -16'sh8000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int s = 0; s < 3; s++) begin
        pick_config();
        if (ph == 0 && s == 1) hold_req = 1;
        repeat (120) send_random();
      end
    end

    drain();
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
